// ----- rtl/core/key_matrix_scan_with_wake_core_assert.svh -----
// assertion macros for the key matrix scanner
`ifndef KEY_MATRIX_SCAN_WITH_WAKE_CORE_ASSERT_SVH
`define KEY_MATRIX_SCAN_WITH_WAKE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define KMSW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kmsw assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define KMSW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kmsw assertion failed");

`endif

// ----- rtl/core/kmsw_pkg.sv -----
package kmsw_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned RowW   = 4;
  localparam int unsigned ColW   = 3;
  localparam int unsigned DriveW = 9;
  localparam int unsigned ImgW   = 8;
  localparam int unsigned NibW   = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_DRIVE      = 3'd0,
    CMD_PRESS      = 3'd1,
    CMD_RELEASE    = 3'd2,
    CMD_ON_PRESS   = 3'd3,
    CMD_ON_RELEASE = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [NibW-1:0] in_low;
    logic [NibW-1:0] in_high;
    logic            on_bit;
    logic            wake;
    logic            raise_irq;
    logic            pending_write;
    logic            pending_value;
  } res_t;

endpackage

// ----- rtl/core/key_matrix_scan_with_wake_core.sv -----
// key matrix scanner with wake and interrupt signalling
//
// input channel: one transaction per event (drive change, key press or
// release, ON press or release) together with the cpu shutdown and
// interrupt flags sampled for that event.
// output channel: one transaction per input event carrying the rebuilt
// input image as two nibbles, the ON state, the wake and interrupt request
// and the pending-flag write.
// the result is registered in the result register, or in the skid register while a result is stalled.
// throughput: one event per cycle while in_ready_o is high; the matrix, ON flag and image update
// in the accepting cycle, so the next event sees them at once.
// a result register plus a one-entry skid register sit on the output, so
// one further event is taken while a result is stalled; in_ready_o falls
// only when both are full and rises again once the receiver takes one.
// reset: all keys released, ON released, image zero, no result pending.
module key_matrix_scan_with_wake_core #(
  parameter int unsigned ROWS = 9,
  parameter int unsigned COLS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kmsw_pkg::CmdW-1:0]     cmd_i,
  input  logic [kmsw_pkg::RowW-1:0]     key_row_i,
  input  logic [kmsw_pkg::ColW-1:0]     key_col_i,
  input  logic [kmsw_pkg::DriveW-1:0]   drive_lines_i,
  input  logic                          cpu_shutdown_i,
  input  logic                          irq_enable_i,
  input  logic                          irq_service_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kmsw_pkg::NibW-1:0]     in_low_o,
  output logic [kmsw_pkg::NibW-1:0]     in_high_o,
  output logic                          on_bit_o,
  output logic                          wake_o,
  output logic                          raise_irq_o,
  output logic                          pending_write_o,
  output logic                          pending_value_o
);

  logic [COLS-1:0]           mat_q [ROWS];
  logic [COLS-1:0]           mat_d [ROWS];
  logic                      on_q, on_d;
  logic [kmsw_pkg::ImgW-1:0] img_q, img_d, img_new;

  logic [ROWS-1:0] row_sel;
  logic [COLS-1:0] col_mask;
  logic            key_ok, idle_before, active_after, accept;
  kmsw_pkg::res_t  res;

  kmsw_pkg::res_t  out_q, skid_q;
  logic            out_valid_q, skid_valid_q;

  function automatic logic [kmsw_pkg::ColW-1:0] ColIdx(input int c);
    return kmsw_pkg::ColW'(c);
  endfunction

  assign accept = in_valid_i && in_ready_o;
  assign key_ok = ({1'b0, key_row_i} < 5'(ROWS)) && ({1'b0, key_col_i} < 4'(COLS));
  assign idle_before = (img_q == '0) && !on_q;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_mask[c] = (key_col_i == ColIdx(c));
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic drive_bit;
    if (r < kmsw_pkg::DriveW) begin : g_drv
      assign drive_bit = drive_lines_i[r];
    end else begin : g_nodrv
      assign drive_bit = 1'b0;
    end
    assign row_sel[r] = drive_bit;
  end

  // matrix update for press and release
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      mat_d[r] = mat_q[r];
      if (key_ok && (key_row_i == kmsw_pkg::RowW'(r))) begin
        if (cmd_i == kmsw_pkg::CMD_PRESS) begin
          mat_d[r] = mat_q[r] | col_mask;
        end else if (cmd_i == kmsw_pkg::CMD_RELEASE) begin
          mat_d[r] = mat_q[r] & ~col_mask;
        end
      end
    end
  end

  // image from the updated matrix
  always_comb begin
    img_new = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (row_sel[r]) begin
        img_new = img_new | kmsw_pkg::ImgW'(mat_d[r]);
      end
    end
  end

  assign active_after = (img_new != '0) || on_q;

  always_comb begin
    img_d = img_q;
    on_d  = on_q;
    res   = '0;
    case (cmd_i)
      kmsw_pkg::CMD_DRIVE: begin
        img_d = img_new;
      end
      kmsw_pkg::CMD_PRESS: begin
        if (key_ok) begin
          img_d    = img_new;
          res.wake = cpu_shutdown_i && idle_before && active_after;
          if (irq_enable_i && idle_before && active_after) begin
            res.pending_write = 1'b1;
            res.raise_irq     = irq_service_i;
            res.pending_value = !irq_service_i;
          end else if (!active_after) begin
            res.pending_write = 1'b1;
          end
        end
      end
      kmsw_pkg::CMD_RELEASE: begin
        if (key_ok) begin
          img_d             = img_new;
          res.pending_write = !active_after;
        end
      end
      kmsw_pkg::CMD_ON_PRESS: begin
        on_d          = 1'b1;
        res.wake      = cpu_shutdown_i && !on_q;
        res.raise_irq = irq_service_i && !on_q;
      end
      kmsw_pkg::CMD_ON_RELEASE: begin
        on_d = 1'b0;
      end
      default: begin
      end
    endcase
    res.in_low  = img_d[kmsw_pkg::NibW-1:0];
    res.in_high = img_d[kmsw_pkg::ImgW-1:kmsw_pkg::NibW];
    res.on_bit  = on_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        mat_q[r] <= '0;
      end
      on_q  <= 1'b0;
      img_q <= '0;
    end else if (accept) begin
      for (int r = 0; r < ROWS; r++) begin
        mat_q[r] <= mat_d[r];
      end
      on_q  <= on_d;
      img_q <= img_d;
    end
  end

  // result register with one-entry skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!accept) begin
        out_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      if (out_valid_q) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_ready_o      = !skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign in_low_o        = out_q.in_low;
  assign in_high_o       = out_q.in_high;
  assign on_bit_o        = out_q.on_bit;
  assign wake_o          = out_q.wake;
  assign raise_irq_o     = out_q.raise_irq;
  assign pending_write_o = out_q.pending_write;
  assign pending_value_o = out_q.pending_value;

endmodule

// ----- rtl/core/kmsw_checker.sv -----
`include "key_matrix_scan_with_wake_core_assert.svh"

module kmsw_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [kmsw_pkg::NibW-1:0] in_low_o,
  input logic [kmsw_pkg::NibW-1:0] in_high_o,
  input logic                      on_bit_o,
  input logic                      wake_o,
  input logic                      raise_irq_o,
  input logic                      pending_write_o,
  input logic                      pending_value_o
);

  // a full skid stage means the result register is full too
  `KMSW_ASSERT_IMP(a_stall_has_result, !in_ready_o, out_valid_o)

  `KMSW_ASSERT_IMP(a_pend_value_needs_write, out_valid_o && pending_value_o, pending_write_o)

  // a delivered interrupt clears the pending flag rather than setting it
  `KMSW_ASSERT_IMP(a_irq_clears_pending,
                   out_valid_o && raise_irq_o && pending_write_o, !pending_value_o)

  // waking only happens when something is active afterwards
  `KMSW_ASSERT_IMP(a_wake_needs_activity, out_valid_o && wake_o,
                   on_bit_o || (in_low_o != '0) || (in_high_o != '0))

  `KMSW_ASSERT_NXT(a_stalled_result_holds, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(in_low_o) && $stable(in_high_o))

endmodule

bind key_matrix_scan_with_wake_core kmsw_checker u_kmsw_checker (.*);
